// ----- rtl/ip_fragment_reassembly_tracker_assert.svh -----
// Assertion macros shared by the fragment reassembly tracker RTL.
`ifndef IP_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define IP_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define IFRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next.
`define IFRT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define IFRT_ASSERT(lbl, prop, msg)
`define IFRT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/ifrt_pkg.sv -----
// Package: types, sizes and codes of the fragment reassembly tracker.
`default_nettype none
package ifrt_pkg;
	localparam int MAX_FRAGS = 16;
	localparam int CNT_W     = $clog2(MAX_FRAGS + 1);
	localparam int SUM_W     = 21;
	localparam int END_W     = 17;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FINISH = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_FULL       = 2'd1;
	localparam logic [1:0] STAT_INCOMPLETE = 2'd2;
	localparam logic [1:0] STAT_EMPTY      = 2'd3;

	typedef struct packed {
		logic [15:0] off;
		logic [15:0] len;
		logic [3:0]  ver;
	} frag_t;

	typedef struct packed {
		logic ins;  // sorted insert of the broadcast fragment
		logic rot;  // rotate one place toward the head
	} cell_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/ip_fragment_reassembly_tracker.sv -----
// Top level of the IP fragment reassembly tracker.
//
// Usage: the input channel (in_valid/in_ready) carries one command word:
// insert a fragment descriptor, finish the packet, or clear the table.
// The output channel (out_valid/out_ready) returns result words, each with
// last set on the final word caused by a command. cmd 3 is accepted and
// produces nothing.
// Insert and clear give one word each, registered, so it appears the cycle
// after acceptance. A finish that fails gives one word the same way; a
// finish that succeeds walks the descriptor chain, one word per cycle while
// the receiver keeps up, entry_count words in all, by rotating the cells
// toward the head. After the walk the chain is back in its original order.
// The next command is taken once the output register is free or being
// drained in the same cycle; a stalled receiver holds the result word and
// holds off new commands.
// Reset clears the entry count, the length sum, the stored end and the
// output valid; descriptor cells keep whatever they held and are never
// read until rewritten.
`default_nettype none
`include "ip_fragment_reassembly_tracker_assert.svh"
module ip_fragment_reassembly_tracker
	import ifrt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] frag_offset,
	input  wire logic [15:0] frag_length,
	input  wire logic [3:0]  ip_version,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      out_offset,
	output logic [15:0]      out_length,
	output logic [16:0]      total_length,
	output logic [3:0]       out_version,
	output logic             last
);
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] emit_idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [END_W-1:0] end_q;
	logic             out_valid_q;
	logic [3:0]       first_ver_q;

	logic [1:0]       status_q;
	logic [15:0]      off_q;
	logic [15:0]      len_q;
	logic [END_W-1:0] tot_q;
	logic [3:0]       ver_q;
	logic             last_q;

	cell_ctl_t        ctl;
	frag_t            new_frag;
	frag_t            head;
	logic             any_gt;
	logic             out_free;
	logic             in_acc;
	logic             emit_go;
	logic             full;
	logic             empty;
	logic             match;
	logic             emit_last;
	logic [END_W-1:0] new_end;

	// Output register is free when empty or drained this cycle.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign in_acc    = in_valid && in_ready;
	assign emit_go   = (state_q == ST_EMIT) && out_free;
	assign full      = count_q >= CNT_W'(MAX_FRAGS);
	assign empty     = count_q == '0;
	assign match     = sum_q == SUM_W'(end_q);
	assign emit_last = emit_idx_q == (count_q - CNT_W'(1));
	assign new_end   = END_W'(frag_offset) + END_W'(frag_length);

	assign new_frag = '{off: frag_offset, len: frag_length, ver: ip_version};
	assign ctl.ins  = in_acc && (cmd == CMD_INSERT) && !full;
	assign ctl.rot  = emit_go;

	ifrt_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.new_frag (new_frag),
		.count    (count_q),
		.head     (head),
		.any_gt   (any_gt)
	);

	// Control state: FSM, count, running sum, end of highest fragment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			emit_idx_q  <= '0;
			sum_q       <= '0;
			end_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd)
							CMD_INSERT: begin
								out_valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
									sum_q   <= sum_q + SUM_W'(frag_length);
									// Nothing moved right: the new fragment is highest.
									if (!any_gt) begin
										end_q <= new_end;
									end
								end
							end
							CMD_FINISH: begin
								if (empty || !match) begin
									out_valid_q <= 1'b1;
								end else begin
									state_q    <= ST_EMIT;
									emit_idx_q <= '0;
								end
							end
							CMD_CLEAR: begin
								out_valid_q <= 1'b1;
								count_q     <= '0;
								sum_q       <= '0;
								end_q       <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						emit_idx_q  <= emit_idx_q + CNT_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result word payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			off_q  <= '0;
			len_q  <= '0;
			ver_q  <= '0;
			last_q <= 1'b1;
			case (cmd)
				CMD_INSERT: begin
					status_q <= full ? STAT_FULL : STAT_OK;
					tot_q    <= (full || any_gt) ? end_q : new_end;
				end
				CMD_FINISH: begin
					first_ver_q <= head.ver;
					status_q    <= empty ? STAT_EMPTY : STAT_INCOMPLETE;
					tot_q       <= empty ? '0 : end_q;
				end
				default: begin
					status_q <= STAT_OK;
					tot_q    <= '0;
				end
			endcase
		end else if (emit_go) begin
			status_q <= STAT_OK;
			off_q    <= head.off;
			len_q    <= head.len;
			tot_q    <= end_q;
			ver_q    <= first_ver_q;
			last_q   <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_offset   = off_q;
	assign out_length   = len_q;
	assign total_length = tot_q;
	assign out_version  = ver_q;
	assign last         = last_q;

	`IFRT_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_FRAGS), "entry count above table size")
	`IFRT_ASSERT(a_emit_nonempty, (state_q != ST_EMIT) || (!empty && emit_idx_q < count_q), "emit walk outside occupied entries")
	`IFRT_ASSERT_NEXT(a_finish_walk, in_acc && (cmd == CMD_FINISH) && !empty && match, state_q == ST_EMIT, "successful finish did not start walk")
	`IFRT_ASSERT_NEXT(a_emit_end, emit_go && emit_last, state_q == ST_IDLE && out_valid_q && last_q, "walk did not end on last word")
endmodule
`default_nettype wire

// ----- rtl/ifrt_cell.sv -----
// One descriptor cell of the sorted fragment chain.
`default_nettype none
module ifrt_cell
	import ifrt_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire frag_t     new_frag,
	input  wire frag_t     left_frag,
	input  wire logic      left_gt,
	input  wire frag_t     right_frag,
	input  wire logic      occ,
	input  wire logic      at_end,
	output frag_t          frag,
	output logic           gt
);
	frag_t frag_q;

	assign frag = frag_q;
	// Occupied and strictly above the new offset: this entry moves right.
	assign gt = occ && (frag_q.off > new_frag.off);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_gt) begin
				frag_q <= left_frag;
			end else if (gt || at_end) begin
				frag_q <= new_frag;
			end
		end else if (ctl.rot) begin
			frag_q <= right_frag;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/ifrt_chain.sv -----
// Row of descriptor cells with neighbor wiring and occupancy decode.
`default_nettype none
module ifrt_chain
	import ifrt_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire frag_t            new_frag,
	input  wire logic [CNT_W-1:0] count,
	output frag_t                 head,
	output logic                  any_gt
);
	frag_t             frag   [MAX_FRAGS];
	frag_t             right  [MAX_FRAGS];
	logic [MAX_FRAGS-1:0] gt;
	logic [MAX_FRAGS-1:0] occ;
	logic [MAX_FRAGS-1:0] at_end;
	logic [MAX_FRAGS-1:0] at_last;

	assign head   = frag[0];
	assign any_gt = |gt;

	for (genvar i = 0; i < MAX_FRAGS; i++) begin : g_cell
		assign occ[i]     = count > CNT_W'(i);
		assign at_end[i]  = count == CNT_W'(i);
		assign at_last[i] = count == CNT_W'(i + 1);

		// The last occupied cell wraps the head around on rotation.
		if (i == MAX_FRAGS - 1) begin : g_tail
			assign right[i] = frag[0];
		end else begin : g_mid
			assign right[i] = at_last[i] ? frag[0] : frag[i + 1];
		end

		if (i == 0) begin : g_head
			ifrt_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.new_frag   (new_frag),
				.left_frag  (new_frag),
				.left_gt    (1'b0),
				.right_frag (right[i]),
				.occ        (occ[i]),
				.at_end     (at_end[i]),
				.frag       (frag[i]),
				.gt         (gt[i])
			);
		end else begin : g_body
			ifrt_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.new_frag   (new_frag),
				.left_frag  (frag[i - 1]),
				.left_gt    (gt[i - 1]),
				.right_frag (right[i]),
				.occ        (occ[i]),
				.at_end     (at_end[i]),
				.frag       (frag[i]),
				.gt         (gt[i])
			);
		end
	end
endmodule
`default_nettype wire

// ----- tb/tb_ip_fragment_reassembly_tracker.sv -----
`timescale 1ns / 1ps
// Testbench for the fragment reassembly tracker: scripted and random words, table predictor.
module tb_ip_fragment_reassembly_tracker;
	import ifrt_pkg::*;

	// cmd 3 carries no meaning; the block takes the word and answers nothing
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int SCRIPT_LEN   = 26;
	localparam int RANDOM_WORDS = 320;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] off;
		logic [15:0] len;
		logic [16:0] total;
		logic [3:0]  ver;
		logic        last;
	} frag_result_t;

	// One scripted command word; typed rows carry their single answer inline
	typedef struct packed {
		logic [1:0]  cmd;
		frag_t       frag;
		bit          typed;
		logic [1:0]  status;
		logic [16:0] total;
	} script_row_t;

	typedef enum {RX_OPEN, RX_BUSY, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_INSERT;
	logic [15:0] frag_offset = '0;
	logic [15:0] frag_length = '0;
	logic [3:0]  ip_version = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] out_offset;
	logic [15:0] out_length;
	logic [16:0] total_length;
	logic [3:0]  out_version;
	logic        last;

	// Predictor state: the sorted descriptor table, its fill and the length sum
	frag_t        layout [MAX_FRAGS];
	int           frag_count = 0;
	logic [20:0]  byte_sum = '0;
	frag_result_t pending_results [$];

	bit       failed = 1'b0;
	int       words_sent = 0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	// Directed script: empty table, ignored command, field extremes, a packet that
	// arrives out of order with a fragment ahead of the head and a repeated offset,
	// then a fill to capacity, an insert into the full table and a maximal finish.
	script_row_t script [SCRIPT_LEN] = '{
		'{CMD_FINISH, '{16'hFFFF, 16'hFFFF, 4'hF}, 1'b1, STAT_EMPTY, 17'd0},
		'{CMD_NOP, '{16'hA5A5, 16'h5A5A, 4'h6}, 1'b0, STAT_OK, 17'd0},
		'{CMD_CLEAR, '{16'hFFFF, 16'hFFFF, 4'hF}, 1'b1, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'hFFFF, 16'hFFFF, 4'hF}, 1'b1, STAT_OK, 17'h1FFFE},
		'{CMD_FINISH, '{16'h0000, 16'h0000, 4'h0}, 1'b1, STAT_INCOMPLETE, 17'h1FFFE},
		'{CMD_CLEAR, '{16'h0000, 16'h0000, 4'h0}, 1'b1, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd100, 16'd50, 4'd3}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd0, 16'd100, 4'd0}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd150, 16'd20, 4'd9}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd100, 16'd0, 4'd5}, 1'b0, STAT_OK, 17'd0},
		'{CMD_FINISH, '{16'h1234, 16'h4321, 4'h7}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd170, 16'd10, 4'd0}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd180, 16'd10, 4'd1}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd190, 16'd10, 4'd2}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd200, 16'd10, 4'd3}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd210, 16'd10, 4'd4}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd220, 16'd10, 4'd5}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd230, 16'd10, 4'd6}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd240, 16'd10, 4'd7}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd250, 16'd10, 4'd8}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd260, 16'd10, 4'd9}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd270, 16'd10, 4'd10}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'd280, 16'd10, 4'd11}, 1'b0, STAT_OK, 17'd0},
		'{CMD_INSERT, '{16'h8000, 16'h0001, 4'hA}, 1'b1, STAT_FULL, 17'd290},
		'{CMD_FINISH, '{16'h0000, 16'h0000, 4'h0}, 1'b0, STAT_OK, 17'd0},
		'{CMD_CLEAR, '{16'h0000, 16'h0000, 4'h0}, 1'b1, STAT_OK, 17'd0}
	};

	ip_fragment_reassembly_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.frag_offset  (frag_offset),
		.frag_length  (frag_length),
		.ip_version   (ip_version),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_offset   (out_offset),
		.out_length   (out_length),
		.total_length (total_length),
		.out_version  (out_version),
		.last         (last)
	);

	always #6 clk = ~clk;

	// End of the highest-offset descriptor, zero for an empty table
	function automatic logic [16:0] highest_end();
		if (frag_count == 0)
			return 17'd0;
		return 17'(layout[frag_count - 1].off) + 17'(layout[frag_count - 1].len);
	endfunction

	// Apply one command word to the predicted table and list the words it answers with
	function automatic void track_command(input logic [1:0] c, input frag_t f,
			ref frag_result_t outs [$]);
		frag_result_t r;
		int pos;
		logic [16:0] span;
		outs.delete();
		r = '0;
		r.last = 1'b1;
		case (c)
		CMD_INSERT: begin
			if (frag_count >= MAX_FRAGS) begin
				r.status = STAT_FULL;
			end else begin
				// equal offsets land behind the ones already held
				pos = frag_count;
				while (pos > 0 && layout[pos - 1].off > f.off)
					pos--;
				for (int i = frag_count; i > pos; i--)
					layout[i] = layout[i - 1];
				layout[pos] = f;
				frag_count++;
				byte_sum += f.len;
				r.status = STAT_OK;
			end
			r.total = highest_end();
			outs.push_back(r);
		end
		CMD_FINISH: begin
			if (frag_count == 0) begin
				r.status = STAT_EMPTY;
				outs.push_back(r);
			end else begin
				span = highest_end();
				if (byte_sum != {4'b0, span}) begin
					r.status = STAT_INCOMPLETE;
					r.total = span;
					outs.push_back(r);
				end else begin
					// emit the layout in offset order, version of the head on every word
					for (int i = 0; i < frag_count; i++) begin
						r.status = STAT_OK;
						r.off = layout[i].off;
						r.len = layout[i].len;
						r.total = span;
						r.ver = layout[0].ver;
						r.last = (i == frag_count - 1);
						outs.push_back(r);
					end
				end
			end
		end
		CMD_CLEAR: begin
			frag_count = 0;
			byte_sum = '0;
			outs.push_back(r);
		end
		default: begin
		end
		endcase
	endfunction

	function automatic frag_t rand_frag();
		frag_t f;
		f.off = 16'($urandom);
		f.len = 16'($urandom);
		f.ver = 4'($urandom);
		return f;
	endfunction

	function automatic void check_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	// Drive one command word and hold it until the block takes it; valid stays high
	// so that the next word of a burst can follow at the very next edge.
	task automatic send_word(input logic [1:0] c, input frag_t f, input bit typed = 1'b0,
			input frag_result_t typed_res = '0);
		frag_result_t outs [$];
		in_valid <= 1'b1;
		cmd <= c;
		frag_offset <= f.off;
		frag_length <= f.len;
		ip_version <= f.ver;
		do @(posedge clk); while (!in_ready);
		track_command(c, f, outs);
		if (typed)
			pending_results.push_back(typed_res);
		else
			foreach (outs[i])
				pending_results.push_back(outs[i]);
		if (c != CMD_NOP)
			words_sent++;
	endtask

	// Sender pacing: bursts of random length, random gaps in between
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 6);
		end
		burst_left--;
	endtask

	// Drop valid and hold off until every expected word is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Receiver: stretches of open, busy, sparse and fully held-off acceptance
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
		end
		rx_left--;
		case (rx_mode)
		RX_OPEN:   out_ready <= 1'b1;
		RX_BUSY:   out_ready <= ($urandom_range(0, 3) != 0);
		RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
		default:   out_ready <= 1'b0;
		endcase
	end

	// Compare every accepted result word with the oldest prediction
	always @(posedge clk) begin
		frag_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word, expected none actual status=%0d off=%0h len=%0h",
					$time, status, out_offset, out_length);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 17'(want.status), 17'(status));
				check_field("out_offset", 17'(want.off), 17'(out_offset));
				check_field("out_length", 17'(want.len), 17'(out_length));
				check_field("total_length", want.total, total_length);
				check_field("out_version", 17'(want.ver), 17'(out_version));
				check_field("last", 17'(want.last), 17'(last));
			end
		end
	end

	initial begin : stimulus
		frag_t        parts [MAX_FRAGS];
		frag_t        tmp;
		frag_result_t typed_res;
		int           n, cap, base, flaw, j, first;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the script; typed rows check their own answer, the rest go to the predictor
		foreach (script[i]) begin
			pace();
			typed_res = '0;
			typed_res.status = script[i].status;
			typed_res.total = script[i].total;
			typed_res.last = 1'b1;
			send_word(script[i].cmd, script[i].frag, script[i].typed, typed_res);
		end
		drain();

		while (words_sent < SCRIPT_LEN + RANDOM_WORDS) begin
			if ($urandom_range(0, 9) < 7) begin
				// Packet with contiguous fragments from offset 0, mostly small
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, MAX_FRAGS)
					: $urandom_range(1, 5);
				cap = 65535 / n;
				base = 0;
				for (int i = 0; i < n; i++) begin
					parts[i].off = 16'(base);
					parts[i].len = ($urandom_range(0, 9) == 0) ? 16'd0
						: 16'($urandom_range(0, cap));
					parts[i].ver = 4'($urandom);
					base += parts[i].len;
				end
				// shuffle the arrival order
				for (int i = n - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = parts[i];
					parts[i] = parts[j];
					parts[j] = tmp;
				end
				// flaw: 0 lose a fragment, 1 repeat one, 2 overfill the table, 3 to 5 none
				flaw = $urandom_range(0, 5);
				if ($urandom_range(0, 3) != 0) begin
					pace();
					send_word(CMD_CLEAR, rand_frag());
				end
				first = (flaw == 0) ? 1 : 0;
				for (int i = first; i < n; i++) begin
					pace();
					send_word(CMD_INSERT, parts[i]);
				end
				if (flaw == 1) begin
					pace();
					send_word(CMD_INSERT, parts[$urandom_range(0, n - 1)]);
				end
				if (flaw == 2) begin
					for (int i = n; i <= MAX_FRAGS; i++) begin
						pace();
						send_word(CMD_INSERT, rand_frag());
					end
				end
				pace();
				send_word(CMD_FINISH, rand_frag());
				// a second finish must see the same table
				if ($urandom_range(0, 3) == 0) begin
					pace();
					send_word(CMD_FINISH, rand_frag());
				end
			end else begin
				// Noise: any command with random fields
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					pace();
					send_word(2'($urandom), rand_frag());
				end
			end
			if ($urandom_range(0, 19) == 0)
				drain();
		end

		drain();
		// let a trailing finish walk or stray word show up
		repeat (24) @(posedge clk);
		if (!failed)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
